// File: src/lvr_pkg.sv
// ---------------------------------------------------------------------------
// lvr_pkg: shared types and constants of the low-variance resampler
// Widths, handshake structs and the walk state encoding used by the top
// level and by the cursor walk engine.
// ---------------------------------------------------------------------------
package lvr_pkg;

	// Largest particle set held in the weight memory.
	localparam int PARTICLES = 32;

	// Index and count widths follow from the set size.
	localparam int IDX_W   = $clog2(PARTICLES);
	localparam int CNT_W   = $clog2(PARTICLES + 1);
	localparam int WGT_W   = 16;
	localparam int FRAC_W  = 16;
	localparam int TOT_W   = 21;
	localparam int ACC_W   = 23;
	// Accumulated weight times the set size.
	localparam int ACCN_W  = ACC_W + CNT_W;
	// Start fraction times the set size, plus slot times one unit.
	localparam int UN_W    = FRAC_W + CNT_W + 1;
	// Threshold (fraction*n + slot*65536) * total.
	localparam int RHS_W   = UN_W + TOT_W;
	// Both sides of the threshold compare, widened to a common width.
	localparam int CMP_W   = ACCN_W + FRAC_W;
	localparam int GUARD_W = CNT_W + 2;
	localparam int IN_DW   = WGT_W + FRAC_W;
	localparam int OUT_DW  = ((2 * IDX_W + 7) / 8) * 8;

	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [WGT_W-1:0]   wgt_t;
	typedef logic [FRAC_W-1:0]  frac_t;
	typedef logic [TOT_W-1:0]   tot_t;
	typedef logic [ACCN_W-1:0]  accn_t;
	typedef logic [UN_W-1:0]    un_t;
	typedef logic [RHS_W-1:0]   rhs_t;
	typedef logic [CMP_W-1:0]   cmp_t;
	typedef logic [GUARD_W-1:0] guard_t;

	localparam cnt_t N_MAX = cnt_t'(PARTICLES);

	// Weight memory write request from the loader.
	typedef struct packed {
		logic en;
		idx_t addr;
		wgt_t data;
	} wr_req_t;

	// Run start request, raised on the beat that closes a set.
	typedef struct packed {
		logic  go;
		cnt_t  n;
		frac_t frac;
		tot_t  total;
	} run_req_t;

	// Cursor walk sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_PRIME,
		ST_CMP,
		ST_STEP
	} walk_state_t;

endpackage

// File: src/low_variance_resampler_top.sv
// ---------------------------------------------------------------------------
// low_variance_resampler_top: systematic particle resampler
// Loads unnormalized weights one beat per cycle while no run is active, then
// on the closing beat walks the cursor over the stored weights and emits one
// chosen index per loaded particle.
// Throughput: weight beats are taken one per cycle while no run is active.
// Walk: the closing beat starts INIT (first weight read), then PRIME (scaled
// accumulate and threshold set up), then CMP; each cursor step costs one memory
// read and one scaled accumulate, at most 2n+2 steps over a run of n results.
// The next set may load while the final result still waits at the output.
// Reset: counters, running total and walk sequencer clear at once; the weight
// memory is not cleared and only entries of the current set are read.
// ---------------------------------------------------------------------------
module low_variance_resampler_top (
	input  logic                       clk,
	input  logic                       arst_n,
	// s_tdata: weight [15:0], start_fraction [31:16]
	input  logic [lvr_pkg::IN_DW-1:0]  s_tdata,
	// s_tlast: last_weight
	input  logic                       s_tlast,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// m_tdata: slot [4:0], chosen_index [9:5], zero fill above
	output logic [lvr_pkg::OUT_DW-1:0] m_tdata,
	// m_tuser: zero_total
	output logic                       m_tuser,
	// m_tlast: last_result
	output logic                       m_tlast,
	output logic                       m_tvalid,
	input  logic                       m_tready
);

	lvr_pkg::cnt_t   count_q;
	lvr_pkg::tot_t   total_q;
	lvr_pkg::wgt_t   weight;
	lvr_pkg::frac_t  start_fraction;
	logic            accept;
	logic            has_room;
	lvr_pkg::cnt_t   count_nxt;
	lvr_pkg::tot_t   total_nxt;
	lvr_pkg::wr_req_t  wr;
	lvr_pkg::run_req_t run;
	logic            busy;
	lvr_pkg::idx_t   res_slot;
	lvr_pkg::idx_t   res_index;

	assign weight         = s_tdata[lvr_pkg::WGT_W-1:0];
	assign start_fraction = s_tdata[lvr_pkg::IN_DW-1:lvr_pkg::WGT_W];

	// Weight beats are taken only while no run is walking.
	assign s_tready = !busy;
	assign accept   = s_tvalid && s_tready;
	assign has_room = count_q < lvr_pkg::N_MAX;

	// Beats beyond a full set are dropped from the memory and the total.
	assign count_nxt = has_room ? count_q + lvr_pkg::cnt_t'(1) : count_q;
	assign total_nxt = has_room ? total_q + lvr_pkg::tot_t'(weight) : total_q;

	assign wr.en   = accept && has_room;
	assign wr.addr = count_q[lvr_pkg::IDX_W-1:0];
	assign wr.data = weight;

	assign run.go    = accept && s_tlast;
	assign run.n     = count_nxt;
	assign run.frac  = start_fraction;
	assign run.total = total_nxt;

	// Set count and running total; the closing beat hands them to the walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			total_q <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				count_q <= '0;
				total_q <= '0;
			end else begin
				count_q <= count_nxt;
				total_q <= total_nxt;
			end
		end
	end

	lvr_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.run       (run),
		.busy      (busy),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res_slot  (res_slot),
		.res_index (res_index),
		.res_zero  (m_tuser),
		.res_last  (m_tlast)
	);

	assign m_tdata = lvr_pkg::OUT_DW'({res_index, res_slot});

endmodule

// File: src/lvr_walk.sv
// ---------------------------------------------------------------------------
// lvr_walk: weight memory and systematic cursor walk
// Holds the loaded weights in a one-port-read synchronous memory and walks
// the cursor over them, one memory read and one accumulate per step, and
// emits one result per slot through a registered output stage.
// ---------------------------------------------------------------------------
module lvr_walk (
	input  logic                clk,
	input  logic                arst_n,
	input  lvr_pkg::wr_req_t    wr,
	input  lvr_pkg::run_req_t   run,
	output logic                busy,
	output logic                res_valid,
	input  logic                res_ready,
	output lvr_pkg::idx_t       res_slot,
	output lvr_pkg::idx_t       res_index,
	output logic                res_zero,
	output logic                res_last
);

	// Weight memory, read data registered.
	lvr_pkg::wgt_t mem [lvr_pkg::PARTICLES];
	lvr_pkg::wgt_t rd_data_q;
	logic          rd_en;
	lvr_pkg::idx_t rd_addr;

	// Run context.
	lvr_pkg::walk_state_t state_q, state_nxt;
	lvr_pkg::cnt_t   n_q;
	lvr_pkg::frac_t  frac_q;
	lvr_pkg::tot_t   total_q;
	logic            zero_q;
	lvr_pkg::un_t    un_q;
	lvr_pkg::accn_t  acc_n_q;
	lvr_pkg::rhs_t   rhs_q;
	lvr_pkg::idx_t   cursor_q;
	lvr_pkg::idx_t   slot_q;
	lvr_pkg::guard_t guard_q;

	// Output stage.
	logic          out_valid_q;
	lvr_pkg::idx_t out_slot_q;
	lvr_pkg::idx_t out_index_q;
	logic          out_zero_q;
	logic          out_last_q;

	// Datapath terms.
	logic           below;
	logic           out_free;
	logic           emit;
	logic           step_go;
	logic           slot_last;
	lvr_pkg::idx_t  cursor_nxt;
	lvr_pkg::accn_t weight_n;
	lvr_pkg::rhs_t  rhs_step;

	assign out_free  = !out_valid_q || res_ready;
	assign below     = {acc_n_q, lvr_pkg::FRAC_W'(0)} < lvr_pkg::cmp_t'(rhs_q);
	assign slot_last = (lvr_pkg::cnt_t'(slot_q) + lvr_pkg::cnt_t'(1)) == n_q;
	assign cursor_nxt = ((lvr_pkg::cnt_t'(cursor_q) + lvr_pkg::cnt_t'(1)) == n_q) ?
		'0 : lvr_pkg::idx_t'(cursor_q + lvr_pkg::idx_t'(1));
	// Weight scaled by the set size, added into the scaled accumulator.
	assign weight_n = lvr_pkg::accn_t'(rd_data_q) * lvr_pkg::accn_t'(n_q);
	// One unit of threshold per slot is the total shifted up by the fraction width.
	assign rhs_step = lvr_pkg::rhs_t'({total_q, lvr_pkg::FRAC_W'(0)});

	// Memory write from the loader and registered read for the walk.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lvr_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state, memory read requests and emit decisions.
	always_comb begin
		state_nxt = state_q;
		rd_en     = 1'b0;
		rd_addr   = '0;
		emit      = 1'b0;
		step_go   = 1'b0;
		case (state_q)
			lvr_pkg::ST_IDLE: begin
				if (run.go) begin
					state_nxt = lvr_pkg::ST_INIT;
				end
			end
			lvr_pkg::ST_INIT: begin
				// Fetch the first weight; the cursor starts on it.
				rd_en     = 1'b1;
				state_nxt = lvr_pkg::ST_PRIME;
			end
			lvr_pkg::ST_PRIME: begin
				state_nxt = lvr_pkg::ST_CMP;
			end
			lvr_pkg::ST_CMP: begin
				if (below && guard_q != '0) begin
					step_go   = 1'b1;
					rd_en     = 1'b1;
					rd_addr   = cursor_nxt;
					state_nxt = lvr_pkg::ST_STEP;
				end else if (out_free) begin
					emit = 1'b1;
					if (slot_last) begin
						state_nxt = lvr_pkg::ST_IDLE;
					end
				end
			end
			lvr_pkg::ST_STEP: begin
				state_nxt = lvr_pkg::ST_CMP;
			end
			default: begin
				state_nxt = lvr_pkg::ST_IDLE;
			end
		endcase
	end

	// Run context and arithmetic registers.
	always_ff @(posedge clk) begin
		if (state_q == lvr_pkg::ST_IDLE && run.go) begin
			n_q     <= run.n;
			frac_q  <= run.frac;
			total_q <= run.total;
		end
		if (state_q == lvr_pkg::ST_INIT) begin
			un_q     <= lvr_pkg::un_t'(frac_q) * lvr_pkg::un_t'(n_q);
			cursor_q <= '0;
			slot_q   <= '0;
			guard_q  <= lvr_pkg::guard_t'({n_q, 1'b0}) + lvr_pkg::guard_t'(2);
		end
		if (state_q == lvr_pkg::ST_PRIME) begin
			acc_n_q <= weight_n;
			rhs_q   <= lvr_pkg::rhs_t'(un_q) * lvr_pkg::rhs_t'(total_q);
			zero_q  <= (total_q == '0);
		end
		if (step_go) begin
			cursor_q <= cursor_nxt;
			guard_q  <= guard_q - lvr_pkg::guard_t'(1);
		end
		if (state_q == lvr_pkg::ST_STEP) begin
			acc_n_q <= acc_n_q + weight_n;
		end
		if (emit && !slot_last) begin
			slot_q <= slot_q + lvr_pkg::idx_t'(1);
			rhs_q  <= rhs_q + rhs_step;
		end
	end

	// Output stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output stage payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			out_slot_q  <= slot_q;
			out_index_q <= zero_q ? '0 : cursor_q;
			out_zero_q  <= zero_q;
			out_last_q  <= slot_last;
		end
	end

	assign busy      = (state_q != lvr_pkg::ST_IDLE);
	assign res_valid = out_valid_q;
	assign res_slot  = out_slot_q;
	assign res_index = out_index_q;
	assign res_zero  = out_zero_q;
	assign res_last  = out_last_q;

	// The cursor always points inside the loaded set while comparing.
	a_cursor_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lvr_pkg::ST_CMP |-> lvr_pkg::cnt_t'(cursor_q) < n_q)
		else $error("cursor outside loaded set");

	// A new result only ever comes out of the compare state.
	a_emit_from_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == lvr_pkg::ST_CMP)
		else $error("result emitted outside compare state");

	// With a zero total the cursor never leaves the first particle.
	a_zero_no_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lvr_pkg::ST_CMP && zero_q) |-> cursor_q == '0)
		else $error("cursor moved on zero total");

	// A run is only started while the walk engine is idle.
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		run.go |-> state_q == lvr_pkg::ST_IDLE)
		else $error("run started while busy");

endmodule
